[rtl/extended_message_chunk_reassembly_assert.svh]
// Assertion macros for the chunk reassembly RTL.
`ifndef EXTENDED_MESSAGE_CHUNK_REASSEMBLY_ASSERT_SVH
`define EXTENDED_MESSAGE_CHUNK_REASSEMBLY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EMCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EMCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/emcr_pkg.sv]
// Shared constants, codes and types of the chunk reassembly block.
`default_nettype none
package emcr_pkg;

  localparam int TRACKED_SLOTS  = 4;
  localparam int MAX_PAYLOAD    = 260;
  localparam int FRAGMENT_BYTES = 32;
  localparam int MAX_CHUNK      = 9;
  localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

  localparam int SIDX_W   = (TRACKED_SLOTS > 1) ? $clog2(TRACKED_SLOTS) : 1;
  localparam int CNT_W    = $clog2(FRAGMENT_BYTES + 2);
  localparam int FIDX_W   = $clog2(FRAGMENT_BYTES);
  localparam int RAM_DEPTH = 2 * TRACKED_SLOTS * MAX_PAYLOAD;
  localparam int ADDR_W   = $clog2(RAM_DEPTH);
  localparam int QDEPTH   = 2;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [1:0] CMD_BODY = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [2:0] OC_READ        = 3'd0;
  localparam logic [2:0] OC_PROGRESS    = 3'd1;
  localparam logic [2:0] OC_COMPLETE    = 3'd2;
  localparam logic [2:0] OC_MALFORMED   = 3'd3;
  localparam logic [2:0] OC_UNSUP_CHUNK = 3'd4;
  localparam logic [2:0] OC_UNSUP_TYPE  = 3'd5;
  localparam logic [2:0] OC_RECOVERED   = 3'd6;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] body_byte;
    logic       body_last;
    logic       ext_type_valid;
    logic       is_pps_status;
    logic       is_epr_sink_caps;
    logic       type_tracked;
    logic [1:0] type_slot;
    logic [2:0] data_objects;
    logic [8:0] read_index;
  } emcr_in_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [1:0] completed_slot;
    logic       chunk_request;
    logic [3:0] request_chunk_number;
    logic [8:0] request_data_size;
    logic [7:0] read_byte;
    logic [8:0] read_length;
  } emcr_out_t;

  // One unit of back-end work: a payload copy then a result, or a read.
  typedef struct packed {
    logic              is_read;
    logic [CNT_W-1:0]  count;
    logic              buf_sel;
    logic [ADDR_W-1:0] addr;
    logic              rd_ok;
    emcr_out_t         res;
  } job_t;

  typedef struct packed {
    logic              buf_sel;
    logic [FIDX_W-1:0] idx;
  } frag_rd_t;

  typedef struct packed {
    logic valid;
    logic buf_sel;
  } rel_t;

  typedef struct packed {
    logic       pend;
    logic [1:0] busy;
  } front_stat_t;

  // Base address of one slot's bank in the payload memory.
  function automatic logic [ADDR_W-1:0] region_base(input logic [1:0] slot,
                                                    input logic bank);
    return ADDR_W'((int'(slot) * 2 + int'(bank)) * MAX_PAYLOAD);
  endfunction

endpackage
`default_nettype wire

[rtl/emcr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module emcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/emcr_front.sv]
// Front end: accepts items, buffers message bodies, judges them, tracks slots.
`default_nettype none
module emcr_front import emcr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  emcr_in_t          in_data,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  input  logic [QCNT_W-1:0] q_cnt,
  output logic              push,
  output job_t              push_job,
  input  frag_rd_t          frag_rd,
  output logic [7:0]        frag_byte,
  input  rel_t              rel,
  output front_stat_t       stat
);

  logic [31:0]      timeout_r;
  logic [31:0]      tick_r;
  logic [7:0]       fbuf_r [2][FRAGMENT_BYTES];
  logic [CNT_W-1:0] fcnt_r;
  logic             wr_sel_r;
  logic [1:0]       busy_r;
  logic             pend_r;
  emcr_in_t         jin_r;
  logic             jsel_r;
  logic [CNT_W-1:0] jn_r;

  logic             act_r   [TRACKED_SLOTS];
  logic [8:0]       exp_r   [TRACKED_SLOTS];
  logic [8:0]       rcv_r   [TRACKED_SLOTS];
  logic [3:0]       last_r  [TRACKED_SLOTS];
  logic [31:0]      stamp_r [TRACKED_SLOTS];
  logic             bank_r  [TRACKED_SLOTS];
  logic [8:0]       clen_r  [TRACKED_SLOTS];

  logic             acc;
  logic             body_acc;
  logic             read_acc;
  logic [CNT_W-1:0] fcnt_nxt;

  // Stall on busy buffer (body), judging (read), full queue (last byte, read)
  always_comb begin
    in_stall = 1'b0;
    if (in_data.command == CMD_BODY) begin
      in_stall = busy_r[wr_sel_r] ||
                 (in_data.body_last && (int'(q_cnt) + int'(pend_r) >= QDEPTH));
    end else if (in_data.command == CMD_READ) begin
      in_stall = pend_r || (int'(q_cnt) >= QDEPTH);
    end
  end

  assign acc      = in_valid && !in_stall;
  assign body_acc = acc && (in_data.command == CMD_BODY);
  assign read_acc = acc && (in_data.command == CMD_READ);
  assign fcnt_nxt = (int'(fcnt_r) <= FRAGMENT_BYTES) ? fcnt_r + 1'b1 : fcnt_r;

  assign frag_byte = fbuf_r[frag_rd.buf_sel][frag_rd.idx];
  assign stat      = '{pend: pend_r, busy: busy_r};

  // ---------------- judge the buffered message ----------------
  logic [7:0]        jb [FRAGMENT_BYTES];
  logic [8:0]        size;
  logic              req;
  logic [3:0]        cn;
  logic              ch;
  logic [1:0]        slot;
  logic [SIDX_W-1:0] sidx;
  logic              tracked;
  logic [CNT_W-1:0]  decl;
  logic [9:0]        n10;
  logic [31:0]       age;
  logic              tout;
  logic              act_e;
  logic [8:0]        exp_e;
  logic [8:0]        rcv_e;
  logic [3:0]        last_e;
  logic [31:0]       stamp_e;
  logic [8:0]        exp_b;
  logic [8:0]        rcv_b;
  logic [9:0]        rem10;
  logic [9:0]        frag10;
  logic [9:0]        copy10;
  logic [9:0]        lo10;
  logic              pad_bad;
  logic              recov;

  emcr_out_t         res;
  logic              st_wr;
  logic              n_act;
  logic [8:0]        n_exp;
  logic [8:0]        n_rcv;
  logic [3:0]        n_last;
  logic [31:0]       n_stamp;
  logic              flip;
  logic              len_wr;
  logic [8:0]        len_v;
  logic [9:0]        cnt_v;
  logic [8:0]        off_v;

  always_comb begin
    jb = fbuf_r[jsel_r];
  end

  assign size    = {jb[1][0], jb[0]};
  assign req     = jb[1][2];
  assign cn      = jb[1][6:3];
  assign ch      = jb[1][7];
  assign slot    = jin_r.type_slot;
  assign sidx    = SIDX_W'(slot);
  assign tracked = jin_r.type_tracked && (int'(slot) < TRACKED_SLOTS);
  assign decl    = CNT_W'({jin_r.data_objects, 2'b00});
  assign n10     = 10'(jn_r);

  // Abandon a stale reassembly before using it
  assign age     = tick_r - stamp_r[sidx];
  assign tout    = act_r[sidx] && (age > timeout_r);
  assign act_e   = act_r[sidx] && !tout;
  assign exp_e   = tout ? 9'd0 : exp_r[sidx];
  assign rcv_e   = tout ? 9'd0 : rcv_r[sidx];
  assign last_e  = tout ? 4'd0 : last_r[sidx];
  assign stamp_e = tout ? 32'd0 : stamp_r[sidx];

  assign exp_b  = act_e ? exp_e : size;
  assign rcv_b  = act_e ? rcv_e : 9'd0;
  assign rem10  = 10'(exp_b) - 10'(rcv_b);
  assign frag10 = n10 - 10'd2;
  assign copy10 = (rem10 < frag10) ? rem10 : frag10;
  assign lo10   = copy10 + 10'd2;

  // Nonzero padding after the copied bytes
  always_comb begin
    pad_bad = 1'b0;
    for (int k = 0; k < FRAGMENT_BYTES; k++) begin
      if ((10'(k) >= lo10) && (10'(k) < n10) && (jb[k] != 8'd0)) begin
        pad_bad = 1'b1;
      end
    end
  end

  // Known malformed PPS status layout: size 1 with a four byte payload
  assign recov = jin_r.is_pps_status && ch && (cn == 4'd0) && !req && (size == 9'd1) &&
                 (jin_r.data_objects == 3'd2) && (int'(jn_r) == 8) &&
                 (jb[6] == 8'd0) && (jb[7] == 8'd0) && tracked;

  always_comb begin
    res     = '0;
    res.outcome = OC_MALFORMED;
    st_wr   = 1'b0;
    n_act   = act_e;
    n_exp   = exp_e;
    n_rcv   = rcv_e;
    n_last  = last_e;
    n_stamp = stamp_e;
    flip    = 1'b0;
    len_wr  = 1'b0;
    len_v   = '0;
    cnt_v   = '0;
    off_v   = '0;
    priority if (!jin_r.ext_type_valid || (int'(jn_r) < 2)) begin
      res.outcome = OC_MALFORMED;
    end else if (recov) begin
      res.outcome        = OC_RECOVERED;
      res.completed_slot = slot;
      st_wr   = 1'b1;
      n_act   = 1'b0;
      n_exp   = '0;
      n_rcv   = '0;
      n_last  = '0;
      n_stamp = '0;
      flip    = 1'b1;
      len_wr  = 1'b1;
      len_v   = 9'd4;
      cnt_v   = 10'd4;
    end else if (ch && (int'(cn) > MAX_CHUNK)) begin
      res.outcome = OC_MALFORMED;
    end else if (ch && (jn_r != decl)) begin
      res.outcome = OC_MALFORMED;
    end else if (req && (!ch || (size != 9'd0))) begin
      res.outcome = OC_MALFORMED;
    end else if (req && ((int'(jn_r) != 4) || (jb[2] != 8'd0) || (jb[3] != 8'd0))) begin
      res.outcome = OC_MALFORMED;
    end else if (req && jin_r.is_epr_sink_caps) begin
      res.outcome = OC_COMPLETE;
    end else if (!tracked) begin
      res.outcome = (ch && !req) ? OC_UNSUP_CHUNK : OC_UNSUP_TYPE;
    end else if (req) begin
      res.outcome = OC_UNSUP_TYPE;
    end else if (size == 9'd0) begin
      res.outcome = OC_MALFORMED;
    end else begin
      // From here the timeout clear sticks whatever the outcome
      st_wr = 1'b1;
      priority if (!ch) begin
        if ((n10 != 10'(size) + 10'd2) || (int'(size) > MAX_PAYLOAD) ||
            (int'(jn_r) > FRAGMENT_BYTES)) begin
          res.outcome = OC_MALFORMED;
        end else begin
          res.outcome        = OC_COMPLETE;
          res.completed_slot = slot;
          n_act   = 1'b0;
          n_exp   = '0;
          n_rcv   = '0;
          n_last  = '0;
          n_stamp = '0;
          flip    = 1'b1;
          len_wr  = 1'b1;
          len_v   = size;
          cnt_v   = 10'(size);
        end
      end else if (!act_e && ((cn != 4'd0) || (int'(size) > MAX_PAYLOAD))) begin
        res.outcome = OC_MALFORMED;
      end else if (act_e && ((cn != last_e + 4'd1) || (size != exp_e))) begin
        res.outcome = OC_MALFORMED;
        n_act   = 1'b0;
        n_exp   = '0;
        n_rcv   = '0;
        n_last  = '0;
        n_stamp = '0;
      end else if (pad_bad) begin
        res.outcome = OC_MALFORMED;
        n_act   = 1'b0;
        n_exp   = '0;
        n_rcv   = '0;
        n_last  = '0;
        n_stamp = '0;
      end else if (10'(rcv_b) + copy10 < 10'(exp_b)) begin
        if (int'(cn) + 1 > MAX_CHUNK) begin
          res.outcome = OC_MALFORMED;
          n_act   = 1'b0;
          n_exp   = '0;
          n_rcv   = '0;
          n_last  = '0;
          n_stamp = '0;
        end else begin
          res.outcome              = OC_PROGRESS;
          res.chunk_request        = 1'b1;
          res.request_chunk_number = cn + 4'd1;
          res.request_data_size    = exp_b;
          n_act   = 1'b1;
          n_exp   = exp_b;
          n_rcv   = 9'(10'(rcv_b) + copy10);
          n_last  = cn;
          n_stamp = tick_r;
          cnt_v   = copy10;
          off_v   = rcv_b;
        end
      end else begin
        res.outcome        = OC_COMPLETE;
        res.completed_slot = slot;
        n_act   = 1'b0;
        n_exp   = '0;
        n_rcv   = '0;
        n_last  = '0;
        n_stamp = '0;
        flip    = 1'b1;
        len_wr  = 1'b1;
        len_v   = exp_b;
        cnt_v   = copy10;
        off_v   = rcv_b;
      end
    end
  end

  // ---------------- read request ----------------
  logic              rslot_ok;
  logic [SIDX_W-1:0] rsidx;
  logic [8:0]        rlen;
  logic              rok;

  assign rslot_ok = int'(in_data.type_slot) < TRACKED_SLOTS;
  assign rsidx    = SIDX_W'(in_data.type_slot);
  assign rlen     = rslot_ok ? clen_r[rsidx] : 9'd0;
  assign rok      = rslot_ok && (in_data.read_index < rlen) &&
                    (int'(in_data.read_index) < MAX_PAYLOAD);

  // Queue one job: the judged message, else a read
  always_comb begin
    push     = pend_r || read_acc;
    push_job = '0;
    if (pend_r) begin
      push_job.is_read = 1'b0;
      push_job.count   = CNT_W'(cnt_v);
      push_job.buf_sel = jsel_r;
      push_job.addr    = region_base(slot, !bank_r[sidx]) + ADDR_W'(off_v);
      push_job.res     = res;
    end else begin
      push_job.is_read         = 1'b1;
      push_job.addr            = region_base(in_data.type_slot, bank_r[rsidx]) +
                                 ADDR_W'(in_data.read_index);
      push_job.rd_ok           = rok;
      push_job.res.outcome     = OC_READ;
      push_job.res.read_length = rlen;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      tick_r    <= '0;
      fcnt_r    <= '0;
      wr_sel_r  <= 1'b0;
      busy_r    <= '0;
      pend_r    <= 1'b0;
      for (int s = 0; s < TRACKED_SLOTS; s++) begin
        act_r[s]   <= 1'b0;
        exp_r[s]   <= '0;
        rcv_r[s]   <= '0;
        last_r[s]  <= '0;
        stamp_r[s] <= '0;
        bank_r[s]  <= 1'b0;
        clen_r[s]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
      if (acc && (in_data.command == CMD_TICK)) begin
        tick_r <= tick_r + 32'd1;
      end
      // Advance the body count, switch buffers at the end of a message
      pend_r <= body_acc && in_data.body_last;
      if (body_acc) begin
        if (in_data.body_last) begin
          fcnt_r   <= '0;
          wr_sel_r <= !wr_sel_r;
        end else begin
          fcnt_r <= fcnt_nxt;
        end
      end
      // Lock the judged buffer until its copy is done
      if (rel.valid) begin
        busy_r[rel.buf_sel] <= 1'b0;
      end
      if (pend_r) begin
        busy_r[jsel_r] <= 1'b1;
        if (st_wr) begin
          act_r[sidx]   <= n_act;
          exp_r[sidx]   <= n_exp;
          rcv_r[sidx]   <= n_rcv;
          last_r[sidx]  <= n_last;
          stamp_r[sidx] <= n_stamp;
        end
        if (flip) begin
          bank_r[sidx] <= !bank_r[sidx];
        end
        if (len_wr) begin
          clen_r[sidx] <= len_v;
        end
      end
    end
  end

  // Body bytes and captured header facts
  always_ff @(posedge clk) begin
    if (body_acc) begin
      if (int'(fcnt_r) < FRAGMENT_BYTES) begin
        fbuf_r[wr_sel_r][fcnt_r[FIDX_W-1:0]] <= in_data.body_byte;
      end
      if (in_data.body_last) begin
        jin_r  <= in_data;
        jsel_r <= wr_sel_r;
        jn_r   <= fcnt_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/emcr_queue.sv]
// Short job queue between the front and the back end.
`default_nettype none
module emcr_queue import emcr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  job_t              push_job,
  input  logic              pop,
  output logic              head_valid,
  output job_t              head,
  output logic [QCNT_W-1:0] cnt
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rp_r];
  assign cnt        = cnt_r;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (int'(wp_r) == QDEPTH - 1) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (int'(rp_r) == QDEPTH - 1) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

[rtl/emcr_back.sv]
// Back end: copies fragments into payload memory, serves reads, drives results.
`default_nettype none
module emcr_back import emcr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  job_t              head,
  output logic              pop,
  output frag_rd_t          frag_rd,
  input  logic [7:0]        frag_byte,
  output rel_t              rel,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              out_valid,
  input  logic              out_stall,
  output emcr_out_t         out_data
);

  logic [CNT_W-1:0] cp_idx_r;
  logic             rdp_r;
  emcr_out_t        rdp_res_r;
  logic             rdp_ok_r;
  logic             out_valid_r;
  emcr_out_t        out_data_r;

  logic             out_load;
  logic             rdp_drain;
  logic             emit;

  assign out_load  = !out_valid_r || !out_stall;
  assign rdp_drain = rdp_r && out_load;

  assign frag_rd.buf_sel = head.buf_sel;
  assign frag_rd.idx     = FIDX_W'(cp_idx_r + CNT_W'(2));
  assign ram_waddr       = head.addr + ADDR_W'(cp_idx_r);
  assign ram_wdata       = frag_byte;
  assign ram_raddr       = head.addr;

  // Work on the job at the head: one byte a cycle, then its result, or a read
  always_comb begin
    pop    = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    emit   = 1'b0;
    if (head_valid) begin
      priority if (head.is_read) begin
        if (!rdp_r || out_load) begin
          ram_re = 1'b1;
          pop    = 1'b1;
        end
      end else if (cp_idx_r < head.count) begin
        ram_we = 1'b1;
      end else if (!rdp_r && out_load) begin
        emit = 1'b1;
        pop  = 1'b1;
      end
    end
  end

  assign rel.valid   = emit;
  assign rel.buf_sel = head.buf_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_idx_r    <= '0;
      rdp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ram_we) begin
        cp_idx_r <= cp_idx_r + 1'b1;
      end else if (emit) begin
        cp_idx_r <= '0;
      end
      if (ram_re) begin
        rdp_r <= 1'b1;
      end else if (rdp_drain) begin
        rdp_r <= 1'b0;
      end
      if (rdp_drain || emit) begin
        out_valid_r <= 1'b1;
      end else if (out_load) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payloads
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rdp_res_r <= head.res;
      rdp_ok_r  <= head.rd_ok;
    end
    if (rdp_drain) begin
      out_data_r           <= rdp_res_r;
      out_data_r.read_byte <= rdp_ok_r ? ram_rdata : 8'd0;
    end else if (emit) begin
      out_data_r <= head.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[rtl/extended_message_chunk_reassembly.sv]
// Top level of the extended message chunk reassembly block.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  emcr_in_t   (body byte, tick or read)
//  out      output     out_valid/out_stall emcr_out_t (outcome or read reply)
//  cfg      input      cfg_valid/cfg_ready 32-bit timeout_ticks
//
// Body bytes (while in_stall is low) and ticks are taken one per cycle. A
// last body byte is judged in the following cycle; its result appears after
// the back end has copied the fragment into payload memory, one byte per cycle.
// A read reply passes through the registered memory read port.
// Reset is synchronous; no clearing pass. in_stall rises while the next body
// buffer is still being copied, the job queue lacks room, or a read meets judging.
`default_nettype none
`include "extended_message_chunk_reassembly_assert.svh"
module extended_message_chunk_reassembly import emcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  emcr_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output emcr_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic              push;
  job_t              push_job;
  logic              pop;
  logic              head_valid;
  job_t              head;
  logic [QCNT_W-1:0] q_cnt;
  frag_rd_t          frag_rd;
  logic [7:0]        frag_byte;
  rel_t              rel;
  front_stat_t       fstat;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign cfg_ready = 1'b1;

  emcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_cnt     (q_cnt),
    .push      (push),
    .push_job  (push_job),
    .frag_rd   (frag_rd),
    .frag_byte (frag_byte),
    .rel       (rel),
    .stat      (fstat)
  );

  emcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .cnt        (q_cnt)
  );

  emcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .frag_rd    (frag_rd),
    .frag_byte  (frag_byte),
    .rel        (rel),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  emcr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Checks
  `EMCR_ASSERT_IMP(a_read_room, in_valid && !in_stall && in_data.command == CMD_READ, int'(q_cnt) < QDEPTH, "read transfer accepted without queue room")
  `EMCR_ASSERT_IMP(a_release_busy, rel.valid, fstat.busy[rel.buf_sel], "released a body buffer that was not locked")
  `EMCR_ASSERT_NXT(a_judge_queued, fstat.pend, q_cnt != '0, "judged message did not reach the queue")

endmodule
`default_nettype wire
